[sv/usgp_pkg.sv]
package usgp_pkg;

  // Parser states. Sensor and gain fields share one state each; the field
  // number is held in a separate slot counter.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPE,
    ST_S_COMMA,
    ST_S_FIELD,
    ST_AIRSPEED,
    ST_G_FIRST,
    ST_G_BODY,
    ST_K_COMMA,
    ST_K_FIELD
  } state_e;

  localparam logic [1:0] KIND_GPS      = 2'd0;
  localparam logic [1:0] KIND_SENSOR   = 2'd1;
  localparam logic [1:0] KIND_AIRSPEED = 2'd2;
  localparam logic [1:0] KIND_GAIN     = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0]  LAST_SLOT = 3'd5;
  localparam logic [15:0] ACC_MAX   = 16'hFFFF;

  // Result queue geometry; one byte may produce up to three results.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;
  localparam int MAX_PUSH   = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [15:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]    n;
    result_t [2:0] r;
  } push_t;

endpackage

[sv/usgp_parser.sv]
module usgp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             room_i,
  output usgp_pkg::push_t  push_o
);

  logic                  vld_q, vld_d;
  logic [7:0]            byte_q;
  usgp_pkg::state_e      st_q, st_d;
  logic [15:0]           acc_q, acc_d;
  logic [2:0]            slot_q, slot_d;
  logic                  fire, accept;
  logic                  is_digit, is_space;
  logic [19:0]           acc_mul;
  logic [15:0]           acc_dig;
  usgp_pkg::push_t       push;

  assign fire       = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_digit = (byte_q >= usgp_pkg::CH_ZERO) && (byte_q <= usgp_pkg::CH_NINE);
  assign is_space = (byte_q == usgp_pkg::CH_SPACE);

  // Times ten as two shifts, then the digit, saturating at the top of 16 bits.
  assign acc_mul = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {16'd0, byte_q[3:0]};
  assign acc_dig = (acc_mul > {4'd0, usgp_pkg::ACC_MAX}) ? usgp_pkg::ACC_MAX : acc_mul[15:0];

  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    slot_d = slot_q;
    push   = '0;
    case (st_q)
      usgp_pkg::ST_IDLE: begin
        if (byte_q == usgp_pkg::CH_DOLLAR) st_d = usgp_pkg::ST_TYPE;
      end
      usgp_pkg::ST_TYPE: begin
        if (byte_q == usgp_pkg::CH_S) st_d = usgp_pkg::ST_S_COMMA;
        else if (byte_q == usgp_pkg::CH_G) st_d = usgp_pkg::ST_G_FIRST;
        else if (byte_q == usgp_pkg::CH_K) st_d = usgp_pkg::ST_K_COMMA;
        else st_d = usgp_pkg::ST_IDLE;
      end
      usgp_pkg::ST_S_COMMA, usgp_pkg::ST_K_COMMA: begin
        slot_d = 3'd0;
        if (byte_q != usgp_pkg::CH_COMMA) st_d = usgp_pkg::ST_IDLE;
        else if (st_q == usgp_pkg::ST_S_COMMA) st_d = usgp_pkg::ST_S_FIELD;
        else st_d = usgp_pkg::ST_K_FIELD;
      end
      usgp_pkg::ST_S_FIELD: begin
        if (byte_q == usgp_pkg::CH_COMMA) begin
          push.n    = 2'd1;
          push.r[0] = '{kind: usgp_pkg::KIND_SENSOR, slot: slot_q, value: acc_q, last: 1'b1};
          acc_d     = '0;
          if (slot_q == usgp_pkg::LAST_SLOT) begin
            st_d   = usgp_pkg::ST_AIRSPEED;
            slot_d = 3'd0;
          end else begin
            slot_d = slot_q + 3'd1;
          end
        end else if (is_digit) begin
          acc_d = acc_dig;
        end else if (!is_space) begin
          acc_d = '0;
          st_d  = usgp_pkg::ST_IDLE;
        end
      end
      usgp_pkg::ST_AIRSPEED: begin
        if (byte_q == usgp_pkg::CH_CR) begin
          push.n    = 2'd1;
          push.r[0] = '{kind: usgp_pkg::KIND_AIRSPEED, slot: 3'd0, value: acc_q, last: 1'b1};
          acc_d     = '0;
          st_d      = usgp_pkg::ST_IDLE;
        end else if (is_digit) begin
          acc_d = acc_dig;
        end else if (!is_space) begin
          acc_d = '0;
          st_d  = usgp_pkg::ST_IDLE;
        end
      end
      usgp_pkg::ST_G_FIRST: begin
        // The held prefix goes out ahead of the first body byte.
        push.r[0] = '{kind: usgp_pkg::KIND_GPS, slot: 3'd0,
                      value: {8'd0, usgp_pkg::CH_DOLLAR}, last: 1'b0};
        if (byte_q == usgp_pkg::CH_DOLLAR) begin
          push.n    = 2'd2;
          push.r[1] = '{kind: usgp_pkg::KIND_GPS, slot: 3'd0,
                        value: {8'd0, usgp_pkg::CH_G}, last: 1'b1};
          st_d      = usgp_pkg::ST_TYPE;
        end else begin
          push.n    = 2'd3;
          push.r[1] = '{kind: usgp_pkg::KIND_GPS, slot: 3'd0,
                        value: {8'd0, usgp_pkg::CH_G}, last: 1'b0};
          push.r[2] = '{kind: usgp_pkg::KIND_GPS, slot: 3'd0, value: {8'd0, byte_q}, last: 1'b1};
          st_d      = usgp_pkg::ST_G_BODY;
        end
      end
      usgp_pkg::ST_G_BODY: begin
        if (byte_q == usgp_pkg::CH_DOLLAR) begin
          st_d = usgp_pkg::ST_TYPE;
        end else begin
          push.n    = 2'd1;
          push.r[0] = '{kind: usgp_pkg::KIND_GPS, slot: 3'd0, value: {8'd0, byte_q}, last: 1'b1};
        end
      end
      usgp_pkg::ST_K_FIELD: begin
        if (byte_q == usgp_pkg::CH_CR || byte_q == usgp_pkg::CH_LF) begin
          push.n    = 2'd1;
          push.r[0] = '{kind: usgp_pkg::KIND_GAIN, slot: slot_q, value: acc_q, last: 1'b1};
          acc_d     = '0;
          st_d      = usgp_pkg::ST_IDLE;
        end else if (byte_q == usgp_pkg::CH_COMMA) begin
          push.n    = 2'd1;
          push.r[0] = '{kind: usgp_pkg::KIND_GAIN, slot: slot_q, value: acc_q, last: 1'b1};
          acc_d     = '0;
          if (slot_q == usgp_pkg::LAST_SLOT) st_d = usgp_pkg::ST_IDLE;
          else slot_d = slot_q + 3'd1;
        end else if (is_digit) begin
          acc_d = acc_dig;
        end else if (!is_space) begin
          acc_d = '0;
          st_d  = usgp_pkg::ST_IDLE;
        end
      end
      default: begin
        acc_d = '0;
        st_d  = usgp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    push_o = push;
    if (!fire) push_o.n = 2'd0;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) vld_d = 1'b1;
    else if (fire) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      st_q   <= usgp_pkg::ST_IDLE;
      acc_q  <= '0;
      slot_q <= '0;
    end else begin
      vld_q <= vld_d;
      if (fire) begin
        st_q   <= st_d;
        acc_q  <= acc_d;
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byte_q <= rx_byte_i;
  end

  a_no_push_without_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push_o.n == 2'd0)
    else $error("results pushed while the held byte was not consumed");

  a_triple_only_gps_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd3 |-> st_q == usgp_pkg::ST_G_FIRST)
    else $error("three results outside GPS entry");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> slot_q <= usgp_pkg::LAST_SLOT)
    else $error("field slot beyond the sixth field");

endmodule

[sv/usgp_result_fifo.sv]
module usgp_result_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  usgp_pkg::push_t       push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output usgp_pkg::result_t     head_o
);

  usgp_pkg::result_t               mem_q [usgp_pkg::FIFO_DEPTH];
  logic [usgp_pkg::PTR_W-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [usgp_pkg::CNT_W-1:0]      count_q, count_d;
  logic                            pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign room_o      = count_q <= usgp_pkg::CNT_W'(usgp_pkg::FIFO_DEPTH - usgp_pkg::MAX_PUSH);

  always_comb begin
    wr_ptr_d = wr_ptr_q + usgp_pkg::PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + usgp_pkg::PTR_W'(pop);
    count_d  = count_q + usgp_pkg::CNT_W'(push_i.n) - usgp_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < usgp_pkg::MAX_PUSH; k++) begin
      if (k < int'(push_i.n)) mem_q[wr_ptr_q + usgp_pkg::PTR_W'(k)] <= push_i.r[k];
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= usgp_pkg::CNT_W'(usgp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("push into a queue without room for a full burst");

endmodule

[sv/uplink_sensor_gain_message_parser.sv]
// Uplink message parser. One ASCII byte is taken per input transfer and run
// through a preamble state machine: "$S," yields six sensor fields and a
// carriage-return-ended airspeed in hundredths, "$K," yields up to six gain
// fields, and "$G" forwards '$', 'G' and every following byte to the GPS sink
// until the next '$'. Fields are decimal and saturate at 65535; spaces are
// skipped and any other stray character drops the message silently. Each
// output transfer carries one result; last marks the final result caused by
// a byte. Rate: bytes that produce no result or one result flow at one byte
// per cycle while the sink keeps up. The byte that follows "$G" produces
// three results at once (two if it is itself a '$'); these land in a
// four-entry result queue, and the parser holds its next byte until the
// queue is down to one entry. The queue's room check is what sets the pace.
// The first result of a byte passes through the input register and then the
// result queue before it is offered at the output.
module uplink_sensor_gain_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic [15:0] value_o,
  output logic        last_o
);

  usgp_pkg::push_t    push;
  usgp_pkg::result_t  head;
  logic               room;

  // Input register, state machine and accumulator.
  usgp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue, which also decouples the sink's stall from the parser.
  usgp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o  = head.kind;
  assign slot_o  = head.slot;
  assign value_o = head.value;
  assign last_o  = head.last;

endmodule
